[rtl/vfd_modbus_command_sequencer_defines.svh]
// assertion macros for the spindle drive command sequencer
// used by the top level only; no other dependencies
`ifndef VFD_MODBUS_COMMAND_SEQUENCER_DEFINES_SVH
`define VFD_MODBUS_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define VMCS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VMCS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMCS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VMCS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/vmcs_pkg.sv]
// shared types and constants for the spindle drive command sequencer
// no dependencies
package vmcs_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CurW = IdxW + 1;

  typedef enum logic [2:0] {
    OP_START = 3'd0, OP_POWER = 3'd1, OP_RESP = 3'd2,
    OP_TICK = 3'd3, OP_SHUT = 3'd4, OP_LOAD = 3'd5
  } opcode_t;

  localparam logic [3:0] PH_NONE = 4'd0;
  localparam logic [3:0] PH_CONNECT = 4'd1;
  localparam logic [3:0] PH_MAXRD = 4'd2;
  localparam logic [3:0] PH_MAXFIX = 4'd3;
  localparam logic [3:0] PH_FSET = 4'd4;
  localparam logic [3:0] PH_FSETS = 4'd5;
  localparam logic [3:0] PH_STOP = 4'd6;
  localparam logic [3:0] PH_FWD = 4'd7;
  localparam logic [3:0] PH_REV = 4'd8;
  localparam logic [3:0] PH_FRD = 4'd9;
  localparam logic [3:0] PH_FRDS = 4'd10;
  localparam logic [3:0] PH_FRD6 = 4'd11;
  localparam logic [3:0] PH_STAT = 4'd12;
  localparam logic [3:0] PH_DISC = 4'd13;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_MWRITE = 2'd2;

  localparam logic [7:0] FailMax = 8'd255;
  localparam logic [7:0] SixWords = 8'd6;
  localparam logic [7:0] MeasWord = 8'd2;
  localparam logic [14:0] FullScale = 15'd32767;

  // requests from controller to datapath
  typedef enum logic [2:0] {
    DP_NONE, DP_SCALE, DP_MEAS
  } dp_op_t;

  typedef struct packed {
    logic     go;
    dp_op_t   op;
    logic [31:0] num;
    logic [15:0] den;
  } dp_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } dp_sts_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] power;
    logic        resp_ok;
    logic [15:0] resp_value;
    logic [3:0]  entry_index;
    logic [3:0]  entry_kind;
    logic [15:0] entry_addr;
    logic [15:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  cmd_kind;
    logic [15:0] cmd_addr;
    logic [15:0] cmd_data;
    logic [15:0] power_out;
    logic [15:0] drive_status;
    logic [15:0] max_frequency;
    logic        link_down;
  } out_item_t;
endpackage

[rtl/vmcs_if.sv]
// valid/ready channel interfaces for items and configuration writes
// depends on vmcs_pkg
interface vmcs_in_if import vmcs_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vmcs_out_if import vmcs_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vmcs_cfg_if ();
  logic valid;
  logic ready;
  logic index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/vfd_modbus_command_sequencer.sv]
// Modbus command sequencer for a spindle drive.
// One transaction in on the in_ channel gives exactly one result transaction
// on the out_ channel. The result carries an optional bus command
// (cmd_valid, cmd_kind, cmd_addr, cmd_data) plus the current measured power,
// status word, maximum frequency and link_down flag.
// Items are handled one at a time: in_ready is high only while the block is
// idle. An item that walks no table has its result valid the cycle after it
// is taken. A walk steps the cursor over the 16 entries plus the wrap on each
// phase scan, passes through the exec state for each entry that issues or
// loads, and waits for the divider on each frequency scale and, through the
// bit-serial divide, on each measurement.
// The result is held in an output register until out_ready; no new item is
// taken before it leaves, so a stalled receiver stalls the input.
// The cfg_ channel writes multi_write (index 0) and query_delay_ticks
// (index 1) and is always ready; write only while idle.
// rst_n is synchronous, active low; it clears the table, fail counts and run
// state but out_r, mneg_r, m5_r; sets query_delay_ticks to 100, multi_write to 0.
`include "vfd_modbus_command_sequencer_defines.svh"
module vfd_modbus_command_sequencer import vmcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vmcs_in_if.sink    in_ch,
  vmcs_out_if.source out_ch,
  vmcs_cfg_if.sink   cfg_ch
);
  logic        multi_r;
  logic [15:0] delay_r;
  dp_cmd_t     dp_cmd;
  dp_sts_t     dp_sts;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multi_r <= 1'b0;
      delay_r <= 16'd100;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == 1'b0) multi_r <= cfg_ch.wdata[0];
      else delay_r <= cfg_ch.wdata;
    end
  end

  vmcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.data),
    .cfg_multi(multi_r), .cfg_delay(delay_r),
    .dp_cmd(dp_cmd), .dp_sts(dp_sts)
  );

  vmcs_divider u_div (.clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .sts(dp_sts));

  // checks
  `VMCS_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(in_ch.ready && out_ch.valid), "in and out both open")
  `VMCS_ASSERT_IMPL(a_out_after_in, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after accept")
  `VMCS_ASSERT_IMPL(a_cmd_zero, clk, rst_n, (out_ch.valid && !out_ch.data.cmd_valid) |-> (out_ch.data.cmd_addr == 16'd0), "idle command not zero")
endmodule

[rtl/vmcs_divider.sv]
// datapath: restoring divider for measurements, one quotient bit per cycle,
// and a short divide by full scale for frequency scaling; depends on vmcs_pkg
module vmcs_divider import vmcs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  output dp_sts_t sts
);
  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        scale_r, scale_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [17:0] srem;
  logic [31:0] sq;

  // divide by 32767: x = q0 * 32767 + (x mod 32768 + q0), then correct
  always_comb begin
    srem = 18'(quo_r[14:0]) + 18'(quo_r[31:15]);
    sq = {15'd0, quo_r[31:15]};
    if (srem >= 18'd32767) sq = sq + 32'd1;
    if (srem >= 18'd65534) sq = sq + 32'd1;
    if (srem >= 18'd98301) sq = sq + 32'd1;
  end

  // shift in one numerator bit and try to subtract
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    scale_nxt = 1'b0;
    done_nxt = 1'b0;
    trial = '0;
    if (cmd.go) begin
      quo_nxt = cmd.num;
      rem_nxt = '0;
      den_nxt = cmd.den;
      if (cmd.op == DP_SCALE) begin
        scale_nxt = 1'b1;
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = 6'd32;
        run_nxt = 1'b1;
      end
    end else if (scale_r) begin
      quo_nxt = sq;
      done_nxt = 1'b1;
    end else if (run_r) begin
      trial = {rem_r[15:0], quo_r[31]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      run_r <= 1'b0;
      scale_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
      scale_r <= scale_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.quo = quo_r;
endmodule

[rtl/vmcs_ctrl.sv]
// controller: phase walker over the command table, response and tick handling
// depends on vmcs_pkg; drives the divider through dp_cmd_t / dp_sts_t
module vmcs_ctrl import vmcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_multi,
  input  logic [15:0] cfg_delay,
  output dp_cmd_t     dp_cmd,
  input  dp_sts_t     dp_sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_EXEC, S_DIV, S_MEAS, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]  tk_r [TableDepth], tk_nxt [TableDepth];
  logic [15:0] ta_r [TableDepth], ta_nxt [TableDepth];
  logic [15:0] tv_r [TableDepth], tv_nxt [TableDepth];
  logic [7:0]  fc_r [TableDepth], fc_nxt [TableDepth];
  logic [3:0]  phase_r, phase_nxt;
  logic [CurW-1:0] cur_r, cur_nxt;     // all ones means minus one
  logic [7:0]  words_r, words_nxt;
  logic        chg_r, chg_nxt;
  logic        shut_r, shut_nxt;
  logic [15:0] ptgt_r, ptgt_nxt;
  logic [15:0] flim_r, flim_nxt;
  logic [15:0] meas_r, meas_nxt;
  logic [15:0] stat_r, stat_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        rel_r, rel_nxt;
  logic        busy_r, busy_nxt;
  logic        mneg_r, mneg_nxt;
  logic        m5_r, m5_nxt;
  out_item_t   out_r, out_nxt;

  logic [15:0] pin, pmag, vmag;
  logic [CurW-1:0] cinc;
  logic [IdxW-1:0] ci;
  logic [31:0] prod;
  logic [15:0] q16;
  logic        in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_item = out_r;
  assign ci = cur_r[IdxW-1:0];
  assign cinc = cur_r + 1'b1;

  // power clamp and magnitude
  always_comb begin
    pin = (in_item.power == 16'h8000) ? 16'h8001 : in_item.power;
    pmag = ptgt_r[15] ? (16'd0 - ptgt_r) : ptgt_r;
    vmag = 16'd0 - in_item.resp_value;
    prod = {16'd0, pmag} * {16'd0, flim_r};
    q16 = (dp_sts.quo > 32'd32767) ? 16'd32767 : dp_sts.quo[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    tk_nxt = tk_r; ta_nxt = ta_r; tv_nxt = tv_r; fc_nxt = fc_r;
    phase_nxt = phase_r; cur_nxt = cur_r; words_nxt = words_r;
    chg_nxt = chg_r; shut_nxt = shut_r; ptgt_nxt = ptgt_r; flim_nxt = flim_r;
    meas_nxt = meas_r; stat_nxt = stat_r; wait_nxt = wait_r; rel_nxt = rel_r;
    busy_nxt = busy_r; mneg_nxt = mneg_r; m5_nxt = m5_r; out_nxt = out_r;
    dp_cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_nxt.cmd_valid = 1'b0;
          out_nxt.cmd_kind = CMD_READ;
          out_nxt.cmd_addr = '0;
          out_nxt.cmd_data = '0;
          state_nxt = S_OUT;
          case (opcode_t'(in_item.opcode))
            OP_START: begin
              for (int i = 0; i < TableDepth; i++) fc_nxt[i] = '0;
              words_nxt = '0; chg_nxt = 1'b0; shut_nxt = 1'b0; ptgt_nxt = '0;
              flim_nxt = '0; meas_nxt = '0; stat_nxt = '0; wait_nxt = '0;
              rel_nxt = 1'b0; busy_nxt = 1'b0;
              phase_nxt = PH_CONNECT; cur_nxt = '1;
              state_nxt = S_WALK;
            end
            OP_POWER: begin
              if (pin != ptgt_r) begin
                ptgt_nxt = pin;
                chg_nxt = 1'b1;
              end
            end
            OP_RESP: begin
              if (busy_r && !rel_r) begin
                if (cur_r[CurW-1]) begin
                  busy_nxt = 1'b0;
                end else if (!in_item.resp_ok) begin
                  busy_nxt = 1'b0;
                  if (fc_r[ci] != FailMax) fc_nxt[ci] = fc_r[ci] + 8'd1;
                  if (shut_r) rel_nxt = 1'b1;
                  else begin
                    phase_nxt = PH_CONNECT; cur_nxt = '1; state_nxt = S_WALK;
                  end
                end else begin
                  words_nxt = words_r + 8'd1;
                  busy_nxt = 1'b0;
                  state_nxt = S_WALK;
                  mneg_nxt = 1'b0;
                  case (tk_r[ci])
                    PH_MAXRD: flim_nxt = in_item.resp_value;
                    PH_FRD: begin
                      dp_cmd.go = 1'b1;
                      state_nxt = S_MEAS;
                    end
                    PH_FRDS: begin
                      dp_cmd.go = 1'b1;
                      state_nxt = S_MEAS;
                      mneg_nxt = in_item.resp_value[15];
                    end
                    PH_FRD6: begin
                      if (words_r + 8'd1 == MeasWord) begin
                        dp_cmd.go = 1'b1;
                        state_nxt = S_MEAS;
                      end else if (words_r + 8'd1 < SixWords) begin
                        busy_nxt = 1'b1;
                        state_nxt = S_OUT;
                      end
                    end
                    PH_STAT: stat_nxt = in_item.resp_value;
                    default: ;
                  endcase
                  dp_cmd.op = DP_MEAS;
                  dp_cmd.den = flim_r;
                  dp_cmd.num = (in_item.resp_value[15] && tk_r[ci] == PH_FRDS) ?
                    {16'd0, vmag} * 32'd32767 : {16'd0, in_item.resp_value} * 32'd32767;
                  // zero values and zero limit settle without the divider
                  if (state_nxt == S_MEAS) begin
                    if (in_item.resp_value == 16'd0) begin
                      meas_nxt = '0;
                      state_nxt = (tk_r[ci] == PH_FRD6) ? S_WALK : S_WALK;
                      dp_cmd.go = 1'b0;
                    end else if (flim_r == 16'd0) begin
                      meas_nxt = mneg_nxt ? 16'h8001 : 16'h7fff;
                      dp_cmd.go = 1'b0;
                      state_nxt = S_WALK;
                    end
                  end
                  // six-word read keeps waiting after the measurement
                  m5_nxt = (tk_r[ci] == PH_FRD6) && (words_r + 8'd1 < SixWords);
                  if (m5_nxt && state_nxt == S_WALK) begin
                    busy_nxt = 1'b1;
                    state_nxt = S_OUT;
                  end
                end
              end
            end
            OP_TICK: begin
              if (wait_r != 16'd0 && !rel_r) begin
                wait_nxt = wait_r - 16'd1;
                if (wait_r == 16'd1) state_nxt = S_WALK;
              end
            end
            OP_SHUT: shut_nxt = 1'b1;
            OP_LOAD: begin
              tk_nxt[in_item.entry_index[IdxW-1:0]] = in_item.entry_kind;
              ta_nxt[in_item.entry_index[IdxW-1:0]] = in_item.entry_addr;
              tv_nxt[in_item.entry_index[IdxW-1:0]] = in_item.entry_value;
              chg_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // one cursor step per cycle, until an entry of the phase is found
      S_WALK: begin
        cur_nxt = cinc;
        if (cinc == CurW'(TableDepth)) begin
          cur_nxt = '1;
          words_nxt = '0;
          case (phase_r)
            PH_MAXFIX: phase_nxt = (ptgt_r == 16'd0) ? PH_STOP : PH_FSET;
            PH_FSETS: begin
              if (ptgt_r[15]) phase_nxt = PH_REV;
              else if (ptgt_r != 16'd0) phase_nxt = PH_FWD;
              else phase_nxt = PH_STOP;
            end
            PH_STOP, PH_FWD, PH_REV: phase_nxt = PH_FRD;
            PH_STAT: begin
              if (shut_r) phase_nxt = PH_DISC;
              else if (chg_r) begin
                chg_nxt = 1'b0;
                phase_nxt = PH_MAXRD;
              end else begin
                phase_nxt = PH_FRD;
                wait_nxt = (cfg_delay == 16'd0) ? 16'd1 : cfg_delay;
                state_nxt = S_OUT;
              end
            end
            PH_DISC: begin
              rel_nxt = 1'b1;
              busy_nxt = 1'b0;
              state_nxt = S_OUT;
            end
            default: phase_nxt = phase_r + 4'd1;
          endcase
        end else if (tk_r[cinc[IdxW-1:0]] == phase_r) begin
          state_nxt = S_EXEC;
        end
      end
      // issue the command for the entry under the cursor, or load the limit for a fixed-maximum entry
      S_EXEC: begin
        out_nxt.cmd_addr = ta_r[ci];
        out_nxt.cmd_kind = cfg_multi ? CMD_MWRITE : CMD_WRITE;
        out_nxt.cmd_data = tv_r[ci];
        out_nxt.cmd_valid = 1'b1;
        busy_nxt = 1'b1;
        state_nxt = S_OUT;
        case (tk_r[ci])
          PH_MAXFIX: begin
            flim_nxt = tv_r[ci];
            out_nxt.cmd_valid = 1'b0;
            out_nxt.cmd_kind = CMD_READ;
            out_nxt.cmd_addr = '0;
            out_nxt.cmd_data = '0;
            busy_nxt = busy_r;
            state_nxt = S_WALK;
          end
          PH_FSET, PH_FSETS: begin
            dp_cmd.go = 1'b1;
            dp_cmd.op = DP_SCALE;
            dp_cmd.num = prod;
            dp_cmd.den = 16'd32767;
            m5_nxt = (tk_r[ci] == PH_FSETS) && ptgt_r[15];
            state_nxt = S_DIV;
          end
          PH_CONNECT, PH_STOP, PH_FWD, PH_REV, PH_DISC: ;
          PH_FRD6: begin
            out_nxt.cmd_kind = CMD_READ;
            out_nxt.cmd_data = 16'd6;
          end
          PH_MAXRD, PH_FRD, PH_FRDS, PH_STAT: begin
            out_nxt.cmd_kind = CMD_READ;
            out_nxt.cmd_data = 16'd1;
          end
          default: begin
            out_nxt.cmd_valid = 1'b0;
            out_nxt.cmd_kind = CMD_READ;
            out_nxt.cmd_addr = '0;
            out_nxt.cmd_data = '0;
            busy_nxt = busy_r;
            state_nxt = S_WALK;
          end
        endcase
      end
      S_DIV: begin
        if (dp_sts.done) begin
          out_nxt.cmd_data = m5_r ? (16'd0 - dp_sts.quo[15:0]) : dp_sts.quo[15:0];
          state_nxt = S_OUT;
        end
      end
      S_MEAS: begin
        if (dp_sts.done) begin
          meas_nxt = mneg_r ? (16'd0 - q16) : q16;
          if (m5_r) begin
            busy_nxt = 1'b1;
            state_nxt = S_OUT;
          end else state_nxt = S_WALK;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_nxt.power_out = meas_nxt;
    out_nxt.drive_status = stat_nxt;
    out_nxt.max_frequency = flim_nxt;
    out_nxt.link_down = rel_nxt;
    if (state_r == S_OUT) out_nxt = out_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    mneg_r <= mneg_nxt;
    m5_r <= m5_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < TableDepth; i++) begin
        fc_r[i] <= '0;
        tk_r[i] <= '0;
        ta_r[i] <= '0;
        tv_r[i] <= '0;
      end
      phase_r <= PH_NONE; cur_r <= '1; words_r <= '0; chg_r <= 1'b0;
      shut_r <= 1'b0; ptgt_r <= '0; flim_r <= '0; meas_r <= '0; stat_r <= '0;
      wait_r <= '0; rel_r <= 1'b0; busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tk_r <= tk_nxt; ta_r <= ta_nxt; tv_r <= tv_nxt;
      fc_r <= fc_nxt;
      phase_r <= phase_nxt; cur_r <= cur_nxt; words_r <= words_nxt;
      chg_r <= chg_nxt; shut_r <= shut_nxt; ptgt_r <= ptgt_nxt;
      flim_r <= flim_nxt; meas_r <= meas_nxt; stat_r <= stat_nxt;
      wait_r <= wait_nxt; rel_r <= rel_nxt; busy_r <= busy_nxt;
    end
  end
endmodule

[tb/tb_top.sv]
// regression bench for the spindle drive command sequencer
// depends on vmcs_pkg, the vmcs_*_if channel interfaces and the sequencer rtl
`timescale 1ns / 1ps
module tb_top;
  import vmcs_pkg::*;

  localparam bit CFG_MULTI = 1'b0;
  localparam bit CFG_DELAY = 1'b1;
  localparam longint CycleLimit = 5000000;

  logic clk;
  logic rst_n;
  vmcs_in_if in_ch();
  vmcs_out_if out_ch();
  vmcs_cfg_if cfg_ch();

  vfd_modbus_command_sequencer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sequencer mirror state
  logic        m_multi;
  logic [15:0] m_delay;
  logic [3:0]  m_kind [TableDepth];
  logic [15:0] m_addr [TableDepth];
  logic [15:0] m_val [TableDepth];
  logic [7:0]  m_fails [TableDepth];
  logic [3:0]  m_phase;
  int          m_cursor;
  logic [7:0]  m_words;
  bit          m_change, m_shut, m_released, m_busy;
  int          m_target;
  logic [15:0] m_flim;
  int          m_meas;
  logic [15:0] m_status;
  logic [15:0] m_wait;

  out_item_t expected_q[$];
  int errors;
  int tx_idle_pct, rx_idle_pct;
  int hold_left;
  bit hold_req;
  longint cycles;

  function automatic void clear_run();
    m_phase = PH_NONE; m_cursor = -1; m_words = '0; m_change = 0; m_shut = 0;
    m_target = 0; m_flim = '0; m_meas = 0; m_status = '0; m_wait = '0;
    m_released = 0; m_busy = 0;
  endfunction

  function automatic void reset_mirror();
    m_multi = 1'b0;
    m_delay = 16'd100;
    for (int i = 0; i < TableDepth; i++) begin
      m_kind[i] = '0; m_addr[i] = '0; m_val[i] = '0; m_fails[i] = '0;
    end
    clear_run();
  endfunction

  function automatic longint freq_scale();
    longint mag;
    mag = (m_target < 0) ? -m_target : m_target;
    return mag * m_flim / 32767;
  endfunction

  function automatic int power_from(longint mag, bit neg);
    longint q;
    if (mag == 0) return 0;
    if (m_flim == 0) q = 32767;
    else begin
      q = mag * 32767 / m_flim;
      if (q > 32767) q = 32767;
    end
    return neg ? -int'(q) : int'(q);
  endfunction

  // next phase; 0 means the walk stops here
  function automatic bit next_phase();
    case (m_phase)
      PH_MAXFIX: m_phase = (m_target == 0) ? PH_STOP : PH_FSET;
      PH_FSETS: begin
        if (m_target < 0) m_phase = PH_REV;
        else if (m_target > 0) m_phase = PH_FWD;
        else m_phase = PH_STOP;
      end
      PH_STOP, PH_FWD, PH_REV: m_phase = PH_FRD;
      PH_STAT: begin
        if (m_shut) m_phase = PH_DISC;
        else if (m_change) begin
          m_change = 0;
          m_phase = PH_MAXRD;
        end else begin
          m_phase = PH_FRD;
          m_wait = (m_delay != 0) ? m_delay : 16'd1;
          return 0;
        end
      end
      PH_DISC: begin
        m_released = 1; m_busy = 0;
        return 0;
      end
      default: m_phase = m_phase + 4'd1;
    endcase
    return 1;
  endfunction

  function automatic bit issue_entry(int i, ref out_item_t o);
    logic [15:0] data;
    logic [15:0] words;
    bit rd, wr;
    data = m_val[i]; words = 16'd1; rd = 0; wr = 0;
    case (m_kind[i])
      PH_MAXFIX: m_flim = m_val[i];
      PH_FSET: begin
        wr = 1; data = 16'(freq_scale());
      end
      PH_FSETS: begin
        wr = 1; data = 16'(freq_scale());
        if (m_target < 0) data = -data;
      end
      PH_CONNECT, PH_STOP, PH_FWD, PH_REV, PH_DISC: wr = 1;
      PH_FRD6: begin
        words = 16'd6; rd = 1;
      end
      PH_MAXRD, PH_FRD, PH_FRDS, PH_STAT: rd = 1;
      default: ;
    endcase
    if (!rd && !wr) return 0;
    o.cmd_valid = 1'b1;
    o.cmd_addr = m_addr[i];
    if (rd) begin
      o.cmd_kind = CMD_READ; o.cmd_data = words;
    end else begin
      o.cmd_kind = m_multi ? CMD_MWRITE : CMD_WRITE; o.cmd_data = data;
    end
    m_busy = 1;
    return 1;
  endfunction

  function automatic void walk_table(ref out_item_t o);
    while (1) begin
      m_cursor++;
      if (m_cursor >= TableDepth) begin
        m_cursor = -1;
        m_words = '0;
        if (!next_phase()) return;
      end else if (m_kind[m_cursor] == m_phase && issue_entry(m_cursor, o)) begin
        return;
      end
    end
  endfunction

  function automatic void take_response(bit ok, logic [15:0] value, ref out_item_t o);
    int i;
    i = m_cursor;
    if (i < 0) begin
      m_busy = 0;
      return;
    end
    if (!ok) begin
      m_busy = 0;
      if (m_fails[i] != FailMax) m_fails[i]++;
      if (m_shut) m_released = 1;
      else begin
        m_phase = PH_CONNECT; m_cursor = -1;
        walk_table(o);
      end
      return;
    end
    m_words++;
    case (m_kind[i])
      PH_MAXRD: m_flim = value;
      PH_FRD: m_meas = power_from(value, 0);
      PH_FRDS: begin
        if (value[15]) m_meas = power_from(65536 - value, 1);
        else m_meas = power_from(value, 0);
      end
      PH_FRD6: begin
        if (m_words == MeasWord) m_meas = power_from(value, 0);
        if (m_words < SixWords) return;
      end
      PH_STAT: m_status = value;
      default: ;
    endcase
    m_busy = 0;
    walk_table(o);
  endfunction

  // expected result of one accepted transaction
  function automatic out_item_t sequence_step(in_item_t it);
    out_item_t o;
    int p;
    o = '0;
    p = $signed(it.power);
    if (p < -32767) p = -32767;
    case (opcode_t'(it.opcode))
      OP_START: begin
        clear_run();
        for (int i = 0; i < TableDepth; i++) m_fails[i] = '0;
        m_phase = PH_CONNECT; m_cursor = -1;
        walk_table(o);
      end
      OP_POWER: if (p != m_target) begin
        m_target = p; m_change = 1;
      end
      OP_RESP: if (m_busy && !m_released) take_response(it.resp_ok, it.resp_value, o);
      OP_TICK: if (m_wait != 0 && !m_released) begin
        m_wait--;
        if (m_wait == 0) walk_table(o);
      end
      OP_SHUT: m_shut = 1;
      OP_LOAD: begin
        m_kind[it.entry_index] = it.entry_kind;
        m_addr[it.entry_index] = it.entry_addr;
        m_val[it.entry_index] = it.entry_value;
        m_change = 1;
      end
      default: ;
    endcase
    o.power_out = m_meas[15:0];
    o.drive_status = m_status;
    o.max_frequency = m_flim;
    o.link_down = m_released;
    return o;
  endfunction

  // send one transaction, with a random gap before it
  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(sequence_step(it));
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_MULTI) m_multi = value[0];
    else m_delay = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [2:0] op);
    in_item_t it;
    it = '0;
    it.opcode = op;
    return it;
  endfunction

  task automatic load_entry(logic [3:0] idx, logic [3:0] kind, logic [15:0] addr,
                            logic [15:0] value);
    in_item_t it;
    it = make_item(OP_LOAD);
    it.entry_index = idx; it.entry_kind = kind; it.entry_addr = addr;
    it.entry_value = value;
    send_item(it);
  endtask

  task automatic respond(bit ok, logic [15:0] value);
    in_item_t it;
    it = make_item(OP_RESP);
    it.resp_ok = ok; it.resp_value = value;
    send_item(it);
  endtask

  // an entry for most phases plus one of an unused kind, extremes of address and value, then a full cycle
  task automatic test_directed();
    in_item_t it;
    load_entry(4'd0, PH_CONNECT, 16'hFFFF, 16'hFFFF);
    load_entry(4'd1, PH_MAXRD, 16'h0000, 16'h0000);
    load_entry(4'd2, PH_FSET, 16'h1234, 16'h0000);
    load_entry(4'd3, PH_FSETS, 16'h5678, 16'h0000);
    load_entry(4'd4, PH_REV, 16'h0008, 16'h0002);
    load_entry(4'd5, PH_FRDS, 16'h0010, 16'h0000);
    load_entry(4'd6, PH_FRD6, 16'h0020, 16'h0000);
    load_entry(4'd7, PH_STAT, 16'h0030, 16'h0000);
    load_entry(4'd8, 4'd15, 16'hAAAA, 16'h5555);
    load_entry(4'd15, PH_DISC, 16'h0040, 16'h0001);
    it = make_item(OP_POWER);
    it.power = 16'h8000;
    send_item(it);
    send_item(make_item(OP_START));
    respond(1'b1, 16'h0000);
    respond(1'b1, 16'hFFFF);
    for (int k = 0; k < 5; k++) respond(1'b1, 16'hFFFF);
    respond(1'b1, 16'h8000);
    for (int k = 0; k < 6; k++) respond(1'b1, 16'h7FFF);
    respond(1'b1, 16'hBEEF);
    send_item(make_item(OP_TICK));
    send_item(make_item(OP_TICK));
    send_item(make_item(OP_SHUT));
    respond(1'b0, 16'h0000);
    respond(1'b1, 16'h0000);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'($urandom_range(300));
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly well-formed traffic: responses while busy, ticks while waiting
  task automatic test_random(int count);
    in_item_t it;
    int sel;
    int done_items;
    done_items = 0;
    while (done_items < count) begin
      it = '0;
      it.power = pick_word();
      it.resp_value = pick_word();
      it.entry_index = 4'($urandom());
      it.entry_addr = pick_word();
      it.entry_value = pick_word();
      it.entry_kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 14)) :
                                                 4'($urandom_range(13));
      it.resp_ok = ($urandom_range(99) < 94);
      sel = $urandom_range(99);
      if (sel < 82) begin
        if (m_released || (!m_busy && m_wait == 0)) it.opcode = OP_START;
        else if (m_busy) it.opcode = OP_RESP;
        else it.opcode = OP_TICK;
      end else if (sel < 88) it.opcode = OP_POWER;
      else if (sel < 93) it.opcode = OP_LOAD;
      else if (sel < 95) it.opcode = OP_SHUT;
      else if (sel < 97) it.opcode = OP_START;
      else it.opcode = 3'($urandom_range(7));
      if (!((it.opcode == OP_RESP && !m_busy) || (it.opcode == OP_TICK && m_wait == 0)))
        done_items++;
      send_item(it);
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    test_random(20);
  endtask

  // sender pauses until every result is back, then continues
  task automatic test_drain_pause();
    test_random(30);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    test_random(30);
  endtask

  // receiver with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checking
  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_item, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction expected none actual %h", $time, got);
      end else begin
        exp_item = expected_q.pop_front();
        check_field("cmd_valid", exp_item.cmd_valid, got.cmd_valid);
        check_field("cmd_kind", exp_item.cmd_kind, got.cmd_kind);
        check_field("cmd_addr", exp_item.cmd_addr, got.cmd_addr);
        check_field("cmd_data", exp_item.cmd_data, got.cmd_data);
        check_field("power_out", exp_item.power_out, got.power_out);
        check_field("drive_status", exp_item.drive_status, got.drive_status);
        check_field("max_frequency", exp_item.max_frequency, got.max_frequency);
        check_field("link_down", exp_item.link_down, got.link_down);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("vfd_modbus_command_sequencer regression: fail");
      $finish;
    end
  end

  // test sequence
  initial begin
    errors = 0; cycles = 0; hold_left = 0; hold_req = 1'b0;
    tx_idle_pct = 6; rx_idle_pct = 66;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = 1'b0; cfg_ch.wdata = '0;
    reset_mirror();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_MULTI, 16'd0);
    write_reg(CFG_DELAY, 16'd2);
    test_directed();
    test_random(200);
    go_quiet();

    tx_idle_pct = 66; rx_idle_pct = 6;
    write_reg(CFG_MULTI, 16'd1);
    write_reg(CFG_DELAY, 16'd1);
    test_random(200);
    test_backpressure();
    go_quiet();

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reg(CFG_DELAY, 16'd0);
    test_drain_pause();
    test_random(150);
    go_quiet();

    write_reg(CFG_MULTI, 16'd0);
    write_reg(CFG_DELAY, 16'hFFFF);
    test_random(40);
    go_quiet();

    write_reg(CFG_DELAY, 16'd3);
    test_random(180);
    go_quiet();

    if (errors == 0) begin
      $display("vfd_modbus_command_sequencer regression: pass");
    end else begin
      $display("vfd_modbus_command_sequencer regression: fail");
    end
    $finish;
  end
endmodule
